// File: src/swtlfo_pkg.sv
`default_nettype none

package swtlfo_pkg;

  localparam int unsigned TABLE_SIZE  = 512;
  localparam int unsigned FRAC_BITS   = 20;
  localparam int unsigned SMOOTH_COEF = 1049;
  localparam logic [31:0] STEP_RESET  = 32'd45812984;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [17:0] GAIN_ONE    = 18'd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_PHASE,
    ST_RD_A,
    ST_RD_B,
    ST_MUL_B,
    ST_SUM,
    ST_MUL_D,
    ST_GAIN
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MUL_STEP_HI,
    MUL_STEP_LO,
    MUL_ROM_INV,
    MUL_ROM_FRAC,
    MUL_DEPTH
  } mul_sel_e;

  typedef struct packed {
    logic     capture;
    logic     smooth;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_en;
    logic     phase_en;
    logic     rom_en;
    logic     rom_b;
    logic     u_en;
    logic     gain_en;
  } cmd_t;

  // sine entry k of a 2^tbl_bits table, signed q1.15, taylor series in q30
  function automatic logic [15:0] sine_entry(input int unsigned k,
                                             input int unsigned tbl_bits);
    logic [63:0] four_k;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    four_k = 64'(k) << 2;
    q = four_k >> tbl_bits;
    r = four_k & ((64'd1 << tbl_bits) - 64'd1);
    if (q[0]) begin
      r = (64'd1 << tbl_bits) - r;
    end
    x = (r * HALF_PI_Q30) >> tbl_bits;
    term = x;
    sum = x;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 6;
    sum = (sum > term) ? sum - term : 64'd0;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 20;
    sum = sum + term;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 42;
    sum = (sum > term) ? sum - term : 64'd0;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 72;
    sum = sum + term;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 110;
    sum = (sum > term) ? sum - term : 64'd0;
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 156;
    sum = sum + term;
    v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return (q >= 64'd2) ? 16'(~v[15:0] + 16'd1) : v[15:0];
  endfunction

endpackage

`default_nettype wire

// File: src/swtlfo_ifs.sv
`default_nettype none

interface swtlfo_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] target_freq;
  logic [15:0] target_depth;

  modport source (output valid, output target_freq, output target_depth, input ready);
  modport sink (input valid, input target_freq, input target_depth, output ready);
endinterface

interface swtlfo_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] gain;

  modport source (output valid, output gain, input ready);
  modport sink (input valid, input gain, output ready);
endinterface

`default_nettype wire

// File: src/smoothed_wavetable_tremolo_lfo_core.sv
// Tremolo LFO: each request carries a target frequency (Q16.8 Hz) and a target
// depth (Q1.15); both are smoothed by a one-pole filter, the phase in a sine
// table of TableSize entries advances by smoothed frequency times
// phase_step_per_hz, the sine is interpolated linearly, and the gain
// 1 - depth*(1-sine)/2 in Q1.15 is returned, one result per request. A request
// occupies the block until its gain is written, so a new request is taken only
// after the last is done; the work is five passes through the one shared 33x30
// multiplier plus two reads of the single-port sine table. The finished gain
// sits in an output register, so the next request is taken while it waits.
// The sine table is fixed at elaboration; no fill pass after reset.
// Write phase_step_per_hz only while no request is in progress.
`default_nettype none

module smoothed_wavetable_tremolo_lfo_core #(
  parameter int unsigned TableSize = swtlfo_pkg::TABLE_SIZE
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  swtlfo_in_if.sink        in_ch_i,
  swtlfo_out_if.source     out_ch_o
);

  swtlfo_pkg::cmd_t cmd;
  logic             in_ready;
  logic             out_valid;
  logic [15:0]      gain;

  swtlfo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .out_ready_i (out_ch_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  swtlfo_datapath #(
    .TableSize (TableSize)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .target_freq_i  (in_ch_i.target_freq),
    .target_depth_i (in_ch_i.target_depth),
    .gain_o         (gain)
  );

  assign in_ch_i.ready = in_ready;
  assign out_ch_o.valid = out_valid;
  assign out_ch_o.gain = gain;

endmodule

`default_nettype wire

// File: src/swtlfo_ctrl.sv
`default_nettype none

module swtlfo_ctrl (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  input  wire                logic out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output swtlfo_pkg::cmd_t   cmd_o
);

  swtlfo_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      swtlfo_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = swtlfo_pkg::ST_SMOOTH;
        end
      end
      swtlfo_pkg::ST_SMOOTH: state_d = swtlfo_pkg::ST_MUL_HI;
      swtlfo_pkg::ST_MUL_HI: state_d = swtlfo_pkg::ST_MUL_LO;
      swtlfo_pkg::ST_MUL_LO: state_d = swtlfo_pkg::ST_PHASE;
      swtlfo_pkg::ST_PHASE:  state_d = swtlfo_pkg::ST_RD_A;
      swtlfo_pkg::ST_RD_A:   state_d = swtlfo_pkg::ST_RD_B;
      swtlfo_pkg::ST_RD_B:   state_d = swtlfo_pkg::ST_MUL_B;
      swtlfo_pkg::ST_MUL_B:  state_d = swtlfo_pkg::ST_SUM;
      swtlfo_pkg::ST_SUM:    state_d = swtlfo_pkg::ST_MUL_D;
      swtlfo_pkg::ST_MUL_D:  state_d = swtlfo_pkg::ST_GAIN;
      swtlfo_pkg::ST_GAIN: begin
        if (out_free) begin
          state_d = swtlfo_pkg::ST_IDLE;
        end
      end
      default: state_d = swtlfo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.mul_sel = swtlfo_pkg::MUL_STEP_HI;
    in_ready_o = 1'b0;
    case (state_q)
      swtlfo_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      swtlfo_pkg::ST_SMOOTH: cmd_o.smooth = 1'b1;
      swtlfo_pkg::ST_MUL_HI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = swtlfo_pkg::MUL_STEP_HI;
      end
      swtlfo_pkg::ST_MUL_LO: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = swtlfo_pkg::MUL_STEP_LO;
        cmd_o.acc_en = 1'b1;
      end
      swtlfo_pkg::ST_PHASE: cmd_o.phase_en = 1'b1;
      swtlfo_pkg::ST_RD_A:  cmd_o.rom_en = 1'b1;
      swtlfo_pkg::ST_RD_B: begin
        cmd_o.rom_en = 1'b1;
        cmd_o.rom_b = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = swtlfo_pkg::MUL_ROM_INV;
      end
      swtlfo_pkg::ST_MUL_B: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = swtlfo_pkg::MUL_ROM_FRAC;
        cmd_o.acc_en = 1'b1;
      end
      swtlfo_pkg::ST_SUM: cmd_o.u_en = 1'b1;
      swtlfo_pkg::ST_MUL_D: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = swtlfo_pkg::MUL_DEPTH;
      end
      swtlfo_pkg::ST_GAIN: cmd_o.gain_en = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.gain_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swtlfo_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: src/swtlfo_datapath.sv
`default_nettype none

module swtlfo_datapath #(
  parameter int unsigned TableSize = swtlfo_pkg::TABLE_SIZE
) (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  swtlfo_pkg::cmd_t cmd_i,
  input  wire  logic             cfg_we_i,
  input  wire  logic [31:0]      cfg_wdata_i,
  input  wire  logic [23:0]      target_freq_i,
  input  wire  logic [15:0]      target_depth_i,
  output logic [15:0]            gain_o
);

  localparam int unsigned TblBits  = $clog2(TableSize);
  localparam int unsigned FracBits = swtlfo_pkg::FRAC_BITS;
  localparam int unsigned PhW      = TblBits + FracBits;

  localparam logic [TblBits-1:0] LeadA = TblBits'(1);
  localparam logic [TblBits-1:0] LeadB = TblBits'(2);
  localparam logic [20:0]        FracOne = 21'h100000;
  localparam logic signed [62:0] One35 = 63'sh8_0000_0000;
  localparam logic [61:0]        Half44 = 62'h800_0000_0000;

  // state and config
  logic [31:0]     step_q;
  logic [PhW-1:0]  phase_q, phase_d;
  logic [39:0]     sf_q, sf_d;
  logic [31:0]     sd_q, sd_d;

  // working registers
  logic [23:0]            tf_q;
  logic [15:0]            td_q;
  logic signed [62:0]     prod_q, acc_q;
  logic [15:0]            rom_q;
  logic [28:0]            u_q;
  logic [15:0]            gain_q;

  // sine table, contents fixed at elaboration
  logic [15:0] sine_rom [TableSize];

  for (genvar k = 0; k < TableSize; k++) begin : g_rom
    assign sine_rom[k] = swtlfo_pkg::sine_entry(k, TblBits);
  end

  // frequency smoother, round half away from zero on the step magnitude
  logic [39:0] f_tgt, f_diff;
  logic        f_up;
  logic [50:0] f_scaled;
  always_comb begin
    f_tgt = {tf_q, 16'h0000};
    f_up = f_tgt >= sf_q;
    f_diff = f_up ? f_tgt - sf_q : sf_q - f_tgt;
    f_scaled = 51'(f_diff) * 51'(swtlfo_pkg::SMOOTH_COEF) + 51'h8_0000;
    sf_d = f_up ? sf_q + 40'(f_scaled[50:20]) : sf_q - 40'(f_scaled[50:20]);
  end

  // depth smoother
  logic [31:0] d_tgt, d_diff;
  logic        d_up;
  logic [42:0] d_scaled;
  always_comb begin
    d_tgt = {td_q, 16'h0000};
    d_up = d_tgt >= sd_q;
    d_diff = d_up ? d_tgt - sd_q : sd_q - d_tgt;
    d_scaled = 43'(d_diff) * 43'(swtlfo_pkg::SMOOTH_COEF) + 43'h8_0000;
    sd_d = d_up ? sd_q + 32'(d_scaled[42:20]) : sd_q - 32'(d_scaled[42:20]);
  end

  // phase increment from the two partial products
  logic [52:0] inc_sum;
  always_comb begin
    inc_sum = 53'(acc_q[51:0]) + 53'(prod_q[51:20]);
    phase_d = phase_q + inc_sum[16 +: PhW];
  end

  logic [TblBits-1:0] ip;
  logic [19:0]        frac;
  logic [TblBits-1:0] rom_addr;
  assign ip = phase_q[PhW-1:FracBits];
  assign frac = phase_q[FracBits-1:0];
  assign rom_addr = ip + (cmd_i.rom_b ? LeadB : LeadA);

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [29:0] mul_b;
  always_comb begin
    case (cmd_i.mul_sel)
      swtlfo_pkg::MUL_STEP_HI: begin
        mul_a = {1'b0, step_q};
        mul_b = {10'b0, sf_q[39:20]};
      end
      swtlfo_pkg::MUL_STEP_LO: begin
        mul_a = {1'b0, step_q};
        mul_b = {10'b0, sf_q[19:0]};
      end
      swtlfo_pkg::MUL_ROM_INV: begin
        mul_a = {{17{rom_q[15]}}, rom_q};
        mul_b = {9'b0, FracOne - {1'b0, frac}};
      end
      swtlfo_pkg::MUL_ROM_FRAC: begin
        mul_a = {{17{rom_q[15]}}, rom_q};
        mul_b = {10'b0, frac};
      end
      swtlfo_pkg::MUL_DEPTH: begin
        mul_a = {1'b0, sd_q};
        mul_b = {1'b0, u_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // interpolated sine to (1 - sine) scaled, then depth product to gain
  logic signed [62:0] interp, u_full;
  logic [61:0]        rnd_sum;
  logic [17:0]        rnd;
  logic [15:0]        gain_d;
  always_comb begin
    interp = acc_q + prod_q;
    u_full = One35 - interp;
    rnd_sum = {1'b0, prod_q[60:0]} + Half44;
    rnd = rnd_sum[61:44];
    gain_d = (rnd > swtlfo_pkg::GAIN_ONE) ? 16'd0 : 16'(swtlfo_pkg::GAIN_ONE - rnd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= swtlfo_pkg::STEP_RESET;
      phase_q <= '0;
      sf_q <= '0;
      sd_q <= '0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (cmd_i.smooth) begin
        sf_q <= sf_d;
        sd_q <= sd_d;
      end
      if (cmd_i.phase_en) begin
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tf_q <= target_freq_i;
      td_q <= target_depth_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.acc_en) begin
      acc_q <= prod_q;
    end
    if (cmd_i.rom_en) begin
      rom_q <= sine_rom[rom_addr];
    end
    if (cmd_i.u_en) begin
      u_q <= u_full[36:8];
    end
    if (cmd_i.gain_en) begin
      gain_q <= gain_d;
    end
  end

  assign gain_o = gain_q;

endmodule

`default_nettype wire

// File: src/swtlfo_checker.sv
`default_nettype none

module swtlfo_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] gain_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(gain_i))
    else $error("gain changed while stalled");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> gain_i <= 16'd32768)
    else $error("gain above unity");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("request taken while busy");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result appeared right after accept");

endmodule

bind smoothed_wavetable_tremolo_lfo_core swtlfo_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch_i.valid),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .gain_i      (out_ch_o.gain)
);

`default_nettype wire
